@@ src/pwl_pkg.sv @@
`default_nettype none
package pwl_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned CNT_W = 7;

  typedef enum logic [0:0] {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LD_DIV,
    ST_LD_WAIT,
    ST_LD_WRITE,
    ST_Q_FIRST,
    ST_Q_FIRST_RD,
    ST_Q_LAST,
    ST_Q_LAST_RD,
    ST_Q_SRCH,
    ST_Q_SRCH_RD,
    ST_Q_HI_RD,
    ST_Q_LO,
    ST_Q_LO_RD,
    ST_Q_DIV,
    ST_Q_WAIT,
    ST_Q_NEXT,
    ST_RESULT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       take_req;
    logic       load_slot;
    logic       rd_first;
    logic       rd_last;
    logic       rd_mid;
    logic       rd_hi;
    logic       rd_lo;
    logic       cap_first;
    logic       cap_last;
    logic       srch_step;
    logic       cap_hi;
    logic       cap_lo;
    logic       div_start;
    logic       div_capture;
    logic       write_mem;
    logic       set_exact_hi;
    logic       set_oor;
    logic       set_one;
    logic [1:0] lane;
    logic       out_load;
  } pwl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic kind_query;
    logic found;
    logic oor;
    logic srch_done;
    logic exact_hi;
    logic hi_at_zero;
    logic lo_not_below;
    logic div_done;
    logic out_free;
  } pwl_sts_t;

endpackage
`default_nettype wire

@@ src/pwl_if.sv @@
`default_nettype none
interface pwl_req_if;
  logic        valid;
  logic        ready;
  logic [0:0]  kind;
  logic [5:0]  entry_index;
  logic [31:0] bin_center;
  logic signed [31:0] initial_count;
  logic signed [31:0] out_central;
  logic signed [31:0] out_up;
  logic signed [31:0] out_down;
  logic [0:0]  particle_found;
  logic [31:0] mass;
  modport source (output valid, kind, entry_index, bin_center, initial_count,
                  out_central, out_up, out_down, particle_found, mass, input ready);
  modport sink (input valid, kind, entry_index, bin_center, initial_count,
                out_central, out_up, out_down, particle_found, mass, output ready);
endinterface

interface pwl_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] weight_central;
  logic [31:0] weight_up;
  logic [31:0] weight_down;
  logic [0:0]  out_of_range;
  modport source (output valid, weight_central, weight_up, weight_down, out_of_range,
                  input ready);
  modport sink (input valid, weight_central, weight_up, weight_down, out_of_range,
                output ready);
endinterface

interface pwl_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

@@ src/piecewise_linear_weight_lookup_core.sv @@
`default_nettype none
// load: three ratios computed in turn on the shared 64-bit divider, then one table write
// query: range check, binary search, then three interpolations in turn on the divider
// exact or repeated center skips the interpolations; no particle and out of range skip the search
// throughput: one request at a time, next one taken after the result is registered
// reset: synchronous rst clears control and sets entries_used to 2; table is not cleared
module piecewise_linear_weight_lookup_core #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned FRAC_BITS   = 16
) (
  input wire logic  clk,
  input wire logic  rst,
  pwl_req_if.sink   req,
  pwl_rsp_if.source rsp,
  pwl_cfg_if.sink   cfg
);
  import pwl_pkg::*;

  // command and status between sequencer and datapath
  pwl_cmd_t cmd;
  pwl_sts_t sts;

  // sequencer walks load ratios, range check, search, and three interpolations
  pwl_ctrl u_ctrl (
    .clk, .rst, .req_valid(req.valid), .sts, .cmd, .req_ready(req.ready));

  // datapath holds table memories, search pointers, divider and output register
  pwl_dp #(.MAX_ENTRIES(MAX_ENTRIES), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst, .cmd, .sts, .req, .rsp, .cfg);
endmodule
`default_nettype wire

@@ src/pwl_ram.sv @@
`default_nettype none
module pwl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ src/pwl_div.sv @@
`default_nettype none
// restoring divider, one quotient bit per cycle
module pwl_div #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               busy,
  output logic [NW-1:0]      quo
);
  localparam int unsigned CW = $clog2(NW + 1);
  logic [DW:0]   rem;
  logic [DW-1:0] dreg;
  logic [CW-1:0] cnt;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;

  assign shifted = {rem[DW-1:0], quo[NW-1]};
  assign diff = shifted - {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= num;
      dreg <= den;
    end else if (busy) begin
      if (!diff[DW]) begin
        rem <= diff;
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

@@ src/pwl_ctrl.sv @@
`default_nettype none
module pwl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  input  wire pwl_pkg::pwl_sts_t sts,
  output pwl_pkg::pwl_cmd_t      cmd,
  output logic                   req_ready
);
  import pwl_pkg::*;

  state_t     state, state_next;
  logic [1:0] lane, lane_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      lane  <= '0;
    end else begin
      state <= state_next;
      lane  <= lane_next;
    end
  end

  always_comb begin
    state_next = state;
    lane_next  = lane;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          lane_next = '0;
          if (!sts.kind_query) begin
            state_next = ST_LD_DIV;
          end else if (!sts.found) begin
            state_next = ST_RESULT;
          end else begin
            state_next = ST_Q_FIRST;
          end
        end
      end
      ST_LD_DIV:     state_next = ST_LD_WAIT;
      ST_LD_WAIT: begin
        if (sts.div_done) begin
          if (lane == 2'd2) begin
            state_next = ST_LD_WRITE;
          end else begin
            lane_next  = lane + 2'd1;
            state_next = ST_LD_DIV;
          end
        end
      end
      ST_LD_WRITE:   state_next = ST_RESULT;
      ST_Q_FIRST:    state_next = ST_Q_FIRST_RD;
      ST_Q_FIRST_RD: state_next = ST_Q_LAST;
      ST_Q_LAST:     state_next = ST_Q_LAST_RD;
      ST_Q_LAST_RD:  state_next = sts.oor ? ST_RESULT : ST_Q_SRCH;
      ST_Q_SRCH:     state_next = sts.srch_done ? ST_Q_HI_RD : ST_Q_SRCH_RD;
      ST_Q_SRCH_RD:  state_next = ST_Q_SRCH;
      ST_Q_HI_RD:    state_next = ST_Q_LO;
      ST_Q_LO: begin
        if (sts.exact_hi || sts.hi_at_zero) begin
          state_next = ST_RESULT;
        end else begin
          state_next = ST_Q_LO_RD;
        end
      end
      ST_Q_LO_RD:    state_next = sts.lo_not_below ? ST_RESULT : ST_Q_DIV;
      ST_Q_DIV:      state_next = ST_Q_WAIT;
      ST_Q_WAIT: begin
        if (sts.div_done) begin
          state_next = ST_Q_NEXT;
        end
      end
      ST_Q_NEXT: begin
        if (lane == 2'd2) begin
          state_next = ST_RESULT;
        end else begin
          lane_next  = lane + 2'd1;
          state_next = ST_Q_DIV;
        end
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.lane  = lane;
    req_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready    = 1'b1;
        cmd.take_req = req_valid;
      end
      ST_LD_DIV:     cmd.div_start = 1'b1;
      ST_LD_WAIT:    cmd.div_capture = sts.div_done;
      ST_LD_WRITE:   cmd.write_mem = 1'b1;
      ST_Q_FIRST:    cmd.rd_first = 1'b1;
      ST_Q_FIRST_RD: begin
        cmd.cap_first = 1'b1;
        cmd.rd_last   = 1'b1;
      end
      ST_Q_LAST:     cmd.rd_last = 1'b1;
      ST_Q_LAST_RD: begin
        cmd.cap_last = 1'b1;
        cmd.set_oor  = 1'b1;
      end
      ST_Q_SRCH: begin
        cmd.rd_mid = !sts.srch_done;
        cmd.rd_hi  = sts.srch_done;
      end
      ST_Q_SRCH_RD:  cmd.srch_step = 1'b1;
      ST_Q_HI_RD: begin
        cmd.cap_hi = 1'b1;
        cmd.rd_lo  = 1'b1;
      end
      ST_Q_LO: begin
        cmd.set_exact_hi = sts.exact_hi || sts.hi_at_zero;
        cmd.rd_lo        = 1'b1;
      end
      ST_Q_LO_RD:    cmd.cap_lo = 1'b1;
      ST_Q_DIV:      cmd.div_start = 1'b1;
      ST_Q_WAIT:     cmd.div_capture = sts.div_done;
      ST_RESULT:     cmd.out_load = sts.out_free;
      default:       cmd = '0;
    endcase
    cmd.set_one   = (state == ST_IDLE) && req_valid && sts.kind_query && !sts.found;
    cmd.load_slot = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst) begin
      assert (!(state == ST_LD_WRITE) || lane == 2'd2)
        else $error("table written before all three ratios done");
    end
  end

  property p_ready_only_idle;
    @(posedge clk) disable iff (rst) req_ready |-> state == ST_IDLE;
  endproperty
  assert property (p_ready_only_idle) else $error("request taken while busy");

  property p_start_leads_wait;
    @(posedge clk) disable iff (rst) cmd.div_start |=> (state == ST_LD_WAIT || state == ST_Q_WAIT);
  endproperty
  assert property (p_start_leads_wait) else $error("divider start without wait");

  property p_lane_bound;
    @(posedge clk) disable iff (rst) lane != 2'd3;
  endproperty
  assert property (p_lane_bound) else $error("lane counter overrun");
endmodule
`default_nettype wire

@@ src/pwl_dp.sv @@
`default_nettype none
module pwl_dp #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pwl_pkg::pwl_cmd_t cmd,
  output pwl_pkg::pwl_sts_t      sts,
  pwl_req_if.sink                req,
  pwl_rsp_if.source              rsp,
  pwl_cfg_if.sink                cfg
);
  import pwl_pkg::*;

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  // wide enough for a full 32 x 32 interpolation product
  localparam int unsigned NW = 2 * WORD_W;
  localparam int unsigned SW = AW + 1;

  // request capture
  kind_t              kind_r;
  logic [IDX_W-1:0]   slot_r;
  logic [WORD_W-1:0]  center_r;
  logic signed [WORD_W-1:0] init_r;
  logic signed [WORD_W-1:0] num_r [3];
  logic               found_r;
  logic [WORD_W-1:0]  mass_r;
  logic [CNT_W-1:0]   entries_used;
  logic [SW-1:0]      n_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_used <= CNT_W'(2);
    end else if (cfg.valid) begin
      entries_used <= cfg.data;
    end
  end
  assign cfg.ready = 1'b1;

  always_comb begin
    if (entries_used < CNT_W'(2)) begin
      n_eff = SW'(2);
    end else if (32'(entries_used) > MAX_ENTRIES) begin
      n_eff = SW'(MAX_ENTRIES);
    end else begin
      n_eff = SW'(entries_used);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_req) begin
      kind_r   <= kind_t'(req.kind);
      slot_r   <= req.entry_index;
      center_r <= req.bin_center;
      init_r   <= req.initial_count;
      num_r[0] <= req.out_central;
      num_r[1] <= req.out_up;
      num_r[2] <= req.out_down;
      found_r  <= req.particle_found;
      mass_r   <= req.mass;
    end
  end

  // table memories
  logic [AW-1:0]     raddr, waddr;
  logic [WORD_W-1:0] rd_c, rd_w [3];
  logic [WORD_W-1:0] w_r [3];
  logic              slot_ok;

  assign slot_ok = 32'(slot_r) < MAX_ENTRIES;
  assign waddr = AW'(slot_r);

  pwl_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ENTRIES)) u_centers (
    .clk, .we(cmd.write_mem && slot_ok), .waddr, .wdata(center_r), .raddr, .rdata(rd_c));
  for (genvar g = 0; g < 3; g++) begin : g_w
    pwl_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ENTRIES)) u_w (
      .clk, .we(cmd.write_mem && slot_ok), .waddr, .wdata(w_r[g]), .raddr,
      .rdata(rd_w[g]));
  end

  // binary search
  logic [SW-1:0] lo, hi, mid, hi_sel;
  logic [WORD_W-1:0] c_hi, c_lo;
  logic [WORD_W-1:0] wh [3];
  logic oor_r;

  assign mid = lo + ((hi - lo) >> 1);
  assign hi_sel = (lo >= n_eff) ? n_eff - SW'(1) : lo;

  always_comb begin
    raddr = '0;
    if (cmd.rd_last) begin
      raddr = AW'(n_eff - SW'(1));
    end else if (cmd.rd_mid) begin
      raddr = AW'(mid);
    end else if (cmd.rd_hi) begin
      raddr = AW'(hi_sel);
    end else if (cmd.rd_lo) begin
      raddr = AW'(hi_sel - SW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_first) begin
      c_lo <= rd_c;
      lo   <= '0;
      hi   <= n_eff;
    end
    if (cmd.set_oor) begin
      oor_r <= (mass_r < c_lo) || (mass_r > rd_c);
    end
    if (cmd.srch_step) begin
      if (rd_c < mass_r) begin
        lo <= mid + SW'(1);
      end else begin
        hi <= mid;
      end
    end
    if (cmd.cap_hi) begin
      c_hi  <= rd_c;
      wh[0] <= rd_w[0];
      wh[1] <= rd_w[1];
      wh[2] <= rd_w[2];
    end
  end

  // interpolation and ratio divider
  logic [WORD_W-1:0] wl [3];
  logic [WORD_W-1:0] span, off;
  logic [NW-1:0]     div_num, quo;
  logic [WORD_W-1:0] div_den;
  logic              div_busy, div_start_d;
  logic [WORD_W-1:0] delta;
  logic [63:0]       prod;
  logic [WORD_W-1:0] res_w [3];
  logic              ld_zero;

  always_ff @(posedge clk) begin
    if (cmd.cap_lo) begin
      wl[0] <= rd_w[0];
      wl[1] <= rd_w[1];
      wl[2] <= rd_w[2];
      span  <= c_hi - rd_c;
      if (mass_r <= rd_c) begin
        off <= '0;
      end else if (mass_r - rd_c > c_hi - rd_c) begin
        off <= c_hi - rd_c;
      end else begin
        off <= mass_r - rd_c;
      end
    end
  end

  assign delta = (wh[cmd.lane] >= wl[cmd.lane]) ? wh[cmd.lane] - wl[cmd.lane]
                                                : wl[cmd.lane] - wh[cmd.lane];

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      prod <= 64'(delta) * 64'(off);
    end
  end

  assign ld_zero = (init_r <= 0) || (num_r[cmd.lane] <= 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_start_d <= 1'b0;
    end else begin
      div_start_d <= cmd.div_start;
    end
  end

  always_comb begin
    if (kind_r == KIND_LOAD) begin
      div_num = NW'({num_r[cmd.lane]}) << FRAC_BITS;
      div_den = init_r;
    end else begin
      div_num = NW'(prod);
      div_den = span;
    end
  end

  pwl_div #(.NW(NW), .DW(WORD_W)) u_div (
    .clk, .rst, .start(div_start_d), .num(div_num), .den(div_den),
    .busy(div_busy), .quo);

  assign sts.div_done = !div_start_d && !div_busy && !cmd.div_start;

  always_ff @(posedge clk) begin
    if (cmd.div_capture) begin
      if (kind_r == KIND_LOAD) begin
        if (ld_zero) begin
          w_r[cmd.lane] <= '0;
        end else if (|quo[NW-1:WORD_W]) begin
          w_r[cmd.lane] <= '1;
        end else begin
          w_r[cmd.lane] <= quo[WORD_W-1:0];
        end
      end else if (wh[cmd.lane] >= wl[cmd.lane]) begin
        res_w[cmd.lane] <= wl[cmd.lane] + quo[WORD_W-1:0];
      end else begin
        res_w[cmd.lane] <= wl[cmd.lane] - quo[WORD_W-1:0];
      end
    end
    if (cmd.set_exact_hi) begin
      res_w <= wh;
    end
    if (cmd.cap_lo && !(c_hi > rd_c)) begin
      res_w[0] <= rd_w[0];
      res_w[1] <= rd_w[1];
      res_w[2] <= rd_w[2];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.out_of_range <= 1'b0;
      if (kind_r == KIND_LOAD) begin
        rsp.weight_central <= w_r[0];
        rsp.weight_up      <= w_r[1];
        rsp.weight_down    <= w_r[2];
      end else if (!found_r) begin
        rsp.weight_central <= WORD_W'(1) << FRAC_BITS;
        rsp.weight_up      <= WORD_W'(1) << FRAC_BITS;
        rsp.weight_down    <= WORD_W'(1) << FRAC_BITS;
      end else if (oor_r) begin
        rsp.weight_central <= '0;
        rsp.weight_up      <= '0;
        rsp.weight_down    <= '0;
        rsp.out_of_range   <= 1'b1;
      end else begin
        rsp.weight_central <= res_w[0];
        rsp.weight_up      <= res_w[1];
        rsp.weight_down    <= res_w[2];
      end
    end
  end

  assign sts.kind_query   = req.kind == KIND_QUERY;
  assign sts.found        = req.particle_found;
  assign sts.oor          = (mass_r < c_lo) || (mass_r > rd_c);
  assign sts.srch_done    = !(lo < hi);
  assign sts.exact_hi     = c_hi == mass_r;
  assign sts.hi_at_zero   = hi_sel == '0;
  assign sts.lo_not_below = !(c_hi > rd_c);
  assign sts.out_free     = !rsp.valid || rsp.ready;

  property p_search_bounds;
    @(posedge clk) disable iff (rst) cmd.srch_step |-> (lo < hi);
  endproperty
  assert property (p_search_bounds) else $error("search step with empty interval");

  property p_out_hold;
    @(posedge clk) disable iff (rst) cmd.out_load |-> (!rsp.valid || rsp.ready);
  endproperty
  assert property (p_out_hold) else $error("result overwritten before taken");

  property p_div_idle_start;
    @(posedge clk) disable iff (rst) div_start_d |-> !div_busy;
  endproperty
  assert property (p_div_idle_start) else $error("divider restarted while busy");
endmodule
`default_nettype wire

@@ bench/pwl_scoreboard.sv @@
module pwl_scoreboard #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic clk,
  input  logic rst,
  pwl_req_if   req,
  pwl_rsp_if   rsp,
  pwl_cfg_if   cfg,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import pwl_pkg::*;

  typedef struct packed {
    logic [31:0] central;
    logic [31:0] up;
    logic [31:0] down;
    logic        oor;
  } weights_t;

  logic [31:0] centers_q [MAX_ENTRIES];
  logic [31:0] central_q [MAX_ENTRIES];
  logic [31:0] up_q      [MAX_ENTRIES];
  logic [31:0] down_q    [MAX_ENTRIES];
  logic [CNT_W-1:0] entries_used;
  weights_t expected_weights [$];

  // q16.16 quotient, truncated, zero for non-positive operands, saturating
  function automatic logic [31:0] weight_ratio(logic signed [31:0] num,
                                               logic signed [31:0] den);
    logic [63:0] q;
    if (den <= 0 || num <= 0) return '0;
    q = ({32'b0, num} << FRAC_BITS) / {32'b0, den};
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic logic [31:0] blend(logic [31:0] w0, logic [31:0] w1,
                                        logic [63:0] off, logic [63:0] span);
    logic [63:0] stp;
    if (w1 >= w0) begin
      stp = ({32'b0, w1 - w0} * off) / span;
      return w0 + stp[31:0];
    end
    stp = ({32'b0, w0 - w1} * off) / span;
    return w0 - stp[31:0];
  endfunction

  function automatic weights_t lookup(logic [31:0] m);
    weights_t w;
    int n, lo, hi, mid, i;
    logic [63:0] span, off;
    w = '0;
    n = entries_used;
    if (n < 2) n = 2;
    if (n > MAX_ENTRIES) n = MAX_ENTRIES;
    if (m < centers_q[0] || m > centers_q[n-1]) begin
      w.oor = 1'b1;
      return w;
    end
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (centers_q[mid] < m) lo = mid + 1;
      else hi = mid;
    end
    if (lo >= n) lo = n - 1;
    i = (centers_q[lo] == m || lo == 0) ? lo : lo - 1;
    if (i == lo || centers_q[i+1] <= centers_q[i]) begin
      w.central = central_q[i];
      w.up      = up_q[i];
      w.down    = down_q[i];
      return w;
    end
    span = {32'b0, centers_q[i+1] - centers_q[i]};
    off  = (m > centers_q[i]) ? {32'b0, m - centers_q[i]} : 64'd0;
    if (off > span) off = span;
    w.central = blend(central_q[i], central_q[i+1], off, span);
    w.up      = blend(up_q[i], up_q[i+1], off, span);
    w.down    = blend(down_q[i], down_q[i+1], off, span);
    return w;
  endfunction

  assign pending = expected_weights.size();

  always @(posedge clk) begin
    weights_t w, got;
    if (rst) begin
      entries_used <= CNT_W'(2);
    end else begin
      if (cfg.valid && cfg.ready) entries_used <= cfg.data;
      if (req.valid && req.ready) begin
        w = '0;
        if (kind_t'(req.kind) == KIND_LOAD) begin
          w.central = weight_ratio(req.out_central, req.initial_count);
          w.up      = weight_ratio(req.out_up, req.initial_count);
          w.down    = weight_ratio(req.out_down, req.initial_count);
          if (32'(req.entry_index) < MAX_ENTRIES) begin
            centers_q[req.entry_index] = req.bin_center;
            central_q[req.entry_index] = w.central;
            up_q[req.entry_index]      = w.up;
            down_q[req.entry_index]    = w.down;
          end
        end else if (!req.particle_found) begin
          w.central = 32'(1) << FRAC_BITS;
          w.up      = w.central;
          w.down    = w.central;
        end else begin
          w = lookup(req.mass);
        end
        expected_weights = {expected_weights, w};
      end
      if (rsp.valid && rsp.ready) begin
        got = {rsp.weight_central, rsp.weight_up, rsp.weight_down, rsp.out_of_range};
        if (expected_weights.size() == 0) begin
          errors++;
          $display("%0t: unexpected response %h", $realtime, got);
        end else begin
          w = expected_weights.pop_front();
          if (got.central !== w.central) begin
            errors++;
            $display("%0t: weight_central expected %h actual %h", $realtime, w.central,
                     got.central);
          end
          if (got.up !== w.up) begin
            errors++;
            $display("%0t: weight_up expected %h actual %h", $realtime, w.up, got.up);
          end
          if (got.down !== w.down) begin
            errors++;
            $display("%0t: weight_down expected %h actual %h", $realtime, w.down, got.down);
          end
          if (got.oor !== w.oor) begin
            errors++;
            $display("%0t: out_of_range expected %b actual %b", $realtime, w.oor, got.oor);
          end
        end
      end
    end
  end

  initial errors = 0;
endmodule

@@ bench/piecewise_linear_weight_lookup_core_tb.sv @@
module piecewise_linear_weight_lookup_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pwl_pkg::*;

  localparam int LIMIT = 2_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors, pending;
  int   cycles = 0;
  int   n_loads = 0, n_queries = 0, n_rsp = 0;
  bit   send_idle = 1'b1, recv_idle = 1'b1;
  bit   long_hold_done = 1'b0;

  // stimulus copy of the table, used to aim queries and reloads
  logic [31:0] slot_center [64];
  int          n_active;

  pwl_req_if req ();
  pwl_rsp_if rsp ();
  pwl_cfg_if cfg ();

  piecewise_linear_weight_lookup_core dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  pwl_scoreboard sb (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .cfg     (cfg),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // response side: random ready gaps, one long hold-off to back up the input
  initial begin
    int w;
    rsp.ready <= 1'b0;
    @(posedge clk iff !rst);
    forever begin
      w = recv_idle ? $urandom_range(0, 10) : 0;
      if (!long_hold_done && n_rsp >= 150) begin
        long_hold_done = 1'b1;
        w = 600;
      end
      if (w > 0) begin
        rsp.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!(rsp.valid && rsp.ready));
      n_rsp++;
      if ($urandom_range(0, 39) == 0) recv_idle = !recv_idle;
    end
  end

  // one request; valid stays high into the next one when no gap is drawn
  task automatic issue(logic kind, logic [5:0] idx, logic [31:0] center,
                       logic [31:0] init, logic [31:0] oc, logic [31:0] ou,
                       logic [31:0] od, logic found, logic [31:0] m);
    int gap;
    gap = send_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid          <= 1'b1;
    req.kind           <= kind;
    req.entry_index    <= idx;
    req.bin_center     <= center;
    req.initial_count  <= init;
    req.out_central    <= oc;
    req.out_up         <= ou;
    req.out_down       <= od;
    req.particle_found <= found;
    req.mass           <= m;
    do @(posedge clk); while (!(req.valid && req.ready));
    if (kind == KIND_LOAD) begin
      n_loads++;
      slot_center[idx] = center;
    end else begin
      n_queries++;
    end
    if ($urandom_range(0, 39) == 0) send_idle = !send_idle;
  endtask

  task automatic load(logic [5:0] idx, logic [31:0] center, logic [31:0] init,
                      logic [31:0] oc, logic [31:0] ou, logic [31:0] od);
    issue(KIND_LOAD, idx, center, init, oc, ou, od, 1'($urandom), $urandom);
  endtask

  task automatic query(logic found, logic [31:0] m);
    issue(KIND_QUERY, 6'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
          found, m);
  endtask

  // register writes only once the block has drained
  task automatic set_entries(logic [6:0] v, int used);
    req.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= v;
    do @(posedge clk); while (!(cfg.valid && cfg.ready));
    cfg.valid <= 1'b0;
    n_active = used;
  endtask

  // random positive divisor most of the time, sometimes zero or negative
  function automatic logic [31:0] rand_init();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return $urandom | 32'h8000_0000;
      2: return $urandom_range(1, 255);
      default: return $urandom_range(32'h100, 32'h7FFF_FFFF);
    endcase
  endfunction

  function automatic logic [31:0] rand_out();
    case ($urandom_range(0, 7))
      0: return $urandom | 32'h8000_0000;
      1: return 32'd0;
      2: return $urandom;
      default: return $urandom_range(0, 32'h0400_0000);
    endcase
  endfunction

  // fill slots 0..n-1 with ascending centers, an occasional repeat
  task automatic fill_table(int n);
    logic [31:0] c, stp;
    c = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(0, 32'h0100_0000);
    for (int k = 0; k < n; k++) begin
      load(6'(k), c, rand_init(), rand_out(), rand_out(), rand_out());
      stp = (32'hFFFF_FFFF - c) / (n - k);
      if ($urandom_range(0, 15) != 0) c = c + $urandom_range(1, stp);
    end
  endtask

  // mostly bracketed masses, some exact centers, edges, misses, no-particle and reloads
  task automatic random_request();
    int k, last;
    logic [31:0] lo_c, hi_c;
    last = n_active - 1;
    k = $urandom_range(0, last - 1);
    lo_c = slot_center[k];
    hi_c = slot_center[k+1];
    case ($urandom_range(0, 19))
      0, 1: load(6'($urandom_range(0, 63)), $urandom, rand_init(), rand_out(), rand_out(),
                 rand_out());
      2, 3: load(6'(k), lo_c, rand_init(), rand_out(), rand_out(), rand_out());
      4: query(1'b0, $urandom);
      5: query(1'b1, slot_center[0] - ((slot_center[0] == 0) ? 0 : 1));
      6: query(1'b1, slot_center[last] + ((slot_center[last] == 32'hFFFF_FFFF) ? 0 : 1));
      7: query(1'b1, $urandom);
      8, 9: query(1'b1, slot_center[$urandom_range(0, last)]);
      default:
        query(1'b1, (hi_c > lo_c) ? lo_c + $urandom_range(0, hi_c - lo_c) : lo_c);
    endcase
  endtask

  initial begin
    req.valid <= 1'b0;
    req.kind <= KIND_LOAD;
    req.entry_index <= '0;
    req.bin_center <= '0;
    req.initial_count <= '0;
    req.out_central <= '0;
    req.out_up <= '0;
    req.out_down <= '0;
    req.particle_found <= 1'b0;
    req.mass <= '0;
    cfg.valid <= 1'b0;
    cfg.data <= '0;
    n_active = 2;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: two entries spanning the whole mass range, default count
    load(0, 32'd0, 32'd1, 32'h7FFF_FFFF, 32'd0, 32'h8000_0000);   // saturated, zero, negative
    load(1, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0002_0000, 32'h7FFF_FFFF, 32'd1);
    query(1'b1, 32'd0);                   // exact first center
    query(1'b1, 32'hFFFF_FFFF);           // exact last center
    query(1'b1, 32'h8000_0000);           // interpolated, falling and rising
    query(1'b0, 32'h1234_5678);           // no particle
    load(2, 32'h0000_0001, 32'h8000_0000, 32'd5, 32'd5, 32'd5);  // negative divisor
    load(3, 32'h0000_0002, 32'd0, 32'd5, 32'd5, 32'd5);          // zero divisor
    load(63, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'h0001_0000);
    // narrow table: mass below first and above last center
    load(0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000, 32'h0000_8000);
    load(1, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0000_4000);
    query(1'b1, 32'h0000_FFFF);
    query(1'b1, 32'h0001_0001);
    query(1'b1, 32'h0001_0000);           // repeated center, lower entry wins
    // counts below the minimum act as two
    set_entries(7'd0, 2);
    query(1'b1, 32'h0001_0000);
    set_entries(7'd1, 2);
    query(1'b1, 32'h0000_0000);
    // full table, count above the maximum acts as 64
    set_entries(7'd127, 64);
    fill_table(64);
    query(1'b1, slot_center[63]);
    query(1'b1, slot_center[31] + 1);

    // random phases at several table sizes
    foreach (slot_center[i]) begin end
    for (int ph = 0; ph < 7; ph++) begin
      int n;
      case (ph)
        0: n = 64;
        1: n = 2;
        2: n = 3;
        3: n = 17;
        default: n = $urandom_range(2, 64);
      endcase
      set_entries(7'(n), n);
      fill_table(n);
      repeat (40) random_request();
    end

    req.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (600) @(posedge clk);
    $display("covered %0d loads and %0d queries, table sizes 2 to 64", n_loads, n_queries);
    $display("count register written with 0, 1, 127 and in-range values");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

@@ piecewise_linear_weight_lookup_core.f @@
src/pwl_pkg.sv
src/pwl_if.sv
src/pwl_ram.sv
src/pwl_div.sv
src/pwl_ctrl.sv
src/pwl_dp.sv
src/piecewise_linear_weight_lookup_core.sv
bench/pwl_scoreboard.sv
bench/piecewise_linear_weight_lookup_core_tb.sv
